FILE: rtl/tf2x32_pkg.sv
// Shared types, constants and helper functions for the Threefry2x32 generator.
// No dependencies; used by every module under rtl/.
package tf2x32_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CtrW    = 64;
  localparam int unsigned Rounds  = 20;
  localparam int unsigned GroupSz = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] KsParity = 32'h1bd1_1bda;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyWord0    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord1    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCounterBase = 2'd2;

  localparam logic [4:0] RotTable [8] = '{
    5'd13, 5'd15, 5'd26, 5'd6, 5'd17, 5'd29, 5'd16, 5'd24
  };

  typedef struct packed {
    logic [WordW-1:0] x0;
    logic [WordW-1:0] x1;
  } word_pair_t;

  typedef struct packed {
    logic [WordW-1:0] ks0;
    logic [WordW-1:0] ks1;
    logic [WordW-1:0] ks2;
  } key_sched_t;

  // Key injection applied at the end of a group of four rounds.
  typedef struct packed {
    logic             en;
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
  } inject_t;

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] v,
                                              input logic [4:0] r);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} << r;
    return dbl[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] ks_word(input key_sched_t ks,
                                               input int unsigned idx);
    logic [WordW-1:0] w;
    unique case (idx % 3)
      0:       w = ks.ks0;
      1:       w = ks.ks1;
      default: w = ks.ks2;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/tf2x32_cfg.sv
// Configuration registers and derived key schedule for the Threefry2x32 generator.
// Depends on tf2x32_pkg.
module tf2x32_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tf2x32_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tf2x32_pkg::CtrW-1:0]       cfg_data,
  output tf2x32_pkg::key_sched_t            key_sched,
  output logic [tf2x32_pkg::CtrW-1:0]       counter_base
);

  logic [tf2x32_pkg::WordW-1:0] key0_r;
  logic [tf2x32_pkg::WordW-1:0] key1_r;
  logic [tf2x32_pkg::CtrW-1:0]  base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tf2x32_pkg::RegKeyWord0:    key0_r <= cfg_data[tf2x32_pkg::WordW-1:0];
        tf2x32_pkg::RegKeyWord1:    key1_r <= cfg_data[tf2x32_pkg::WordW-1:0];
        tf2x32_pkg::RegCounterBase: base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key_sched.ks0 = key0_r;
  assign key_sched.ks1 = key1_r;
  assign key_sched.ks2 = key0_r ^ key1_r ^ tf2x32_pkg::KsParity;
  assign counter_base  = base_r;

endmodule

FILE: rtl/tf2x32_round.sv
// One pipeline stage: a single add / rotate / XOR round, with optional key injection.
// Depends on tf2x32_pkg.
module tf2x32_round (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [4:0]              rot_amt,
  input  tf2x32_pkg::inject_t     inj,
  input  logic                    valid_i,
  input  tf2x32_pkg::word_pair_t  data_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output tf2x32_pkg::word_pair_t  data_o,
  input  logic                    ready_i
);

  logic                   valid_r;
  tf2x32_pkg::word_pair_t data_r;
  tf2x32_pkg::word_pair_t data_nxt;
  logic [tf2x32_pkg::WordW-1:0] sum0;
  logic [tf2x32_pkg::WordW-1:0] mix1;

  always_comb begin
    sum0 = data_i.x0 + data_i.x1;
    mix1 = tf2x32_pkg::rotl32(data_i.x1, rot_amt) ^ sum0;
    if (inj.en) begin
      data_nxt.x0 = sum0 + inj.k0;
      data_nxt.x1 = mix1 + inj.k1;
    end else begin
      data_nxt.x0 = sum0;
      data_nxt.x1 = mix1;
    end
  end

  // Take a new item whenever this slot is empty or its item moves on.
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

FILE: rtl/threefry2x32_counter_prng.sv
// Top level of the Threefry2x32-20 counter-based random generator.
// Depends on tf2x32_pkg, tf2x32_cfg and tf2x32_round.
//
// Usage:
//   Input channel (in_valid / in_stall / in_element_index) carries one element
//   index per item. Result channel (out_valid / out_stall / out_random_word0/1)
//   returns the two cipher words for that index, in order.
//   Configuration (cfg_we / cfg_index / cfg_data) writes key_word0 (index 0),
//   key_word1 (index 1) or counter_base (index 2); other indexes are ignored.
//   Write configuration only while no item is in flight.
// Stages: 22 register stages: one for the 64-bit counter add, one for the
//   initial key add, and one per cipher round.
// Throughput: one item per cycle while out_stall is low; each round has its own
//   stage, so a new index may enter every cycle while in_stall is low.
// Reset: synchronous on rst_n low; all stages empty, configuration registers zero.
// Stall: when out_stall is high the last stage holds its item; earlier stages
//   keep filling empty slots, and in_stall rises only once the stage after
//   the input is occupied and cannot move.
module threefry2x32_counter_prng (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tf2x32_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tf2x32_pkg::CtrW-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tf2x32_pkg::WordW-1:0]     in_element_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tf2x32_pkg::WordW-1:0]     out_random_word0,
  output logic [tf2x32_pkg::WordW-1:0]     out_random_word1
);

  localparam int unsigned NumRounds = tf2x32_pkg::Rounds;

  tf2x32_pkg::key_sched_t        key_sched;
  logic [tf2x32_pkg::CtrW-1:0]   counter_base;

  tf2x32_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_sched    (key_sched),
    .counter_base (counter_base)
  );

  // Stage A: counter add.
  logic                          ctr_valid_r;
  logic [tf2x32_pkg::CtrW-1:0]   ctr_r;
  logic                          ctr_ready;
  // Stage B: initial key add.
  logic                          key_valid_r;
  tf2x32_pkg::word_pair_t        key_r;
  logic                          key_ready;

  logic                          rnd_valid [NumRounds+1];
  tf2x32_pkg::word_pair_t        rnd_data  [NumRounds+1];
  logic                          rnd_ready [NumRounds+1];

  assign ctr_ready = !ctr_valid_r || key_ready;
  assign key_ready = !key_valid_r || rnd_ready[0];
  assign in_stall  = !ctr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_valid_r <= 1'b0;
      key_valid_r <= 1'b0;
    end else begin
      if (ctr_ready) ctr_valid_r <= in_valid;
      if (key_ready) key_valid_r <= ctr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_ready && in_valid) begin
      ctr_r <= {{(tf2x32_pkg::CtrW-tf2x32_pkg::WordW){1'b0}}, in_element_index}
               + counter_base;
    end
    if (key_ready && ctr_valid_r) begin
      key_r.x0 <= ctr_r[tf2x32_pkg::WordW-1:0] + key_sched.ks0;
      key_r.x1 <= ctr_r[tf2x32_pkg::CtrW-1:tf2x32_pkg::WordW] + key_sched.ks1;
    end
  end

  assign rnd_valid[0] = key_valid_r;
  assign rnd_data[0]  = key_r;

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    localparam int unsigned Group = i / tf2x32_pkg::GroupSz;
    localparam int unsigned RotIx = (Group % 2) * tf2x32_pkg::GroupSz
                                    + (i % tf2x32_pkg::GroupSz);
    localparam logic [tf2x32_pkg::WordW-1:0] GroupNum = (Group + 1);

    tf2x32_pkg::inject_t inj;

    assign inj.en = ((i % tf2x32_pkg::GroupSz) == (tf2x32_pkg::GroupSz - 1));
    assign inj.k0 = tf2x32_pkg::ks_word(key_sched, Group + 1);
    assign inj.k1 = tf2x32_pkg::ks_word(key_sched, Group + 2) + GroupNum;

    tf2x32_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .rot_amt (tf2x32_pkg::RotTable[RotIx]),
      .inj     (inj),
      .valid_i (rnd_valid[i]),
      .data_i  (rnd_data[i]),
      .ready_o (rnd_ready[i]),
      .valid_o (rnd_valid[i+1]),
      .data_o  (rnd_data[i+1]),
      .ready_i (rnd_ready[i+1])
    );
  end

  assign rnd_ready[NumRounds] = !out_stall;

  assign out_valid        = rnd_valid[NumRounds];
  assign out_random_word0 = rnd_data[NumRounds].x0;
  assign out_random_word1 = rnd_data[NumRounds].x1;

endmodule
